// File: src/vgts_pkg.sv
// ----------------------------------------------------------------------------
// vgts_pkg: shared types and constants of the wind grid sampler
// Field widths, action codes, register indexes, the controller state type and
// the control bundle that drives the weighting and accumulation pipeline.
// ----------------------------------------------------------------------------
package vgts_pkg;

	// Fixed widths of the item and register fields and of the grid word.
	localparam int POS_W     = 24;
	localparam int VEC_W     = 16;
	localparam int CFG_W     = 16;
	localparam int CELL_XW   = 5;
	localparam int CELL_YW   = 5;
	localparam int CELL_ZW   = 4;
	localparam int REG_IDX_W = 2;
	localparam int WORD_W    = 3 * VEC_W;

	// Cell space keeps eight fraction bits; interpolation weights use the same.
	localparam int FRAC_W  = 8;
	localparam int T_W     = 8;
	localparam int COORD_W = 26;
	localparam int BASE_W  = COORD_W - FRAC_W;

	typedef enum logic [1:0] {
		ACT_WRITE     = 2'd0,
		ACT_TRILINEAR = 2'd1,
		ACT_NEAREST   = 2'd2
	} action_t;

	localparam logic [REG_IDX_W-1:0] REG_ROOT_X = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_ROOT_Y = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_ROOT_Z = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECODE,
		ST_ROW,
		ST_ADDR,
		ST_WRITE,
		ST_READ,
		ST_DRAIN,
		ST_RESULT
	} state_t;

	// One decoded axis of a query position.
	typedef struct packed {
		logic              ok;
		logic [BASE_W-1:0] base;
		logic [T_W-1:0]    t;
	} axis_t;

	// Control from the sequencer to the accumulation pipeline.
	typedef struct packed {
		logic           clear;
		logic           issue;
		logic [2:0]     corner;
		logic [T_W-1:0] tx;
		logic [T_W-1:0] ty;
		logic [T_W-1:0] tz;
	} mac_ctrl_t;

endpackage

// File: src/vgts_if.sv
// ----------------------------------------------------------------------------
// vgts_if: channel interfaces of the wind grid sampler
// Item channel, result channel and register write channel, each a valid and
// ready handshake with a source and a sink modport.
// ----------------------------------------------------------------------------
interface vgts_item_if;
	logic                          valid;
	logic                          ready;
	logic [1:0]                    action;
	logic [vgts_pkg::POS_W-1:0]    pos_x;
	logic [vgts_pkg::POS_W-1:0]    pos_y;
	logic [vgts_pkg::POS_W-1:0]    pos_z;
	logic [vgts_pkg::CELL_XW-1:0]  cell_x;
	logic [vgts_pkg::CELL_YW-1:0]  cell_y;
	logic [vgts_pkg::CELL_ZW-1:0]  cell_z;
	logic [vgts_pkg::VEC_W-1:0]    vec_x;
	logic [vgts_pkg::VEC_W-1:0]    vec_y;
	logic [vgts_pkg::VEC_W-1:0]    vec_z;

	modport source (
		output valid, action, pos_x, pos_y, pos_z, cell_x, cell_y, cell_z,
		       vec_x, vec_y, vec_z,
		input  ready
	);
	modport sink (
		input  valid, action, pos_x, pos_y, pos_z, cell_x, cell_y, cell_z,
		       vec_x, vec_y, vec_z,
		output ready
	);
endinterface

interface vgts_result_if #(
	parameter int COMPONENT_BITS = 16
);
	logic                      valid;
	logic                      ready;
	logic [COMPONENT_BITS-1:0] flow_x;
	logic [COMPONENT_BITS-1:0] flow_y;
	logic [COMPONENT_BITS-1:0] flow_z;
	logic                      in_range;

	modport source (
		output valid, flow_x, flow_y, flow_z, in_range,
		input  ready
	);
	modport sink (
		input  valid, flow_x, flow_y, flow_z, in_range,
		output ready
	);
endinterface

interface vgts_cfg_if;
	logic                             valid;
	logic                             ready;
	logic [vgts_pkg::REG_IDX_W-1:0]   index;
	logic [vgts_pkg::CFG_W-1:0]       data;

	modport source (
		output valid, index, data,
		input  ready
	);
	modport sink (
		input  valid, index, data,
		output ready
	);
endinterface

// File: src/vgts_mac.sv
// ----------------------------------------------------------------------------
// vgts_mac: corner weighting and accumulation pipeline
// Forms the trilinear weight of each corner, multiplies the three components
// read from the grid, sums the corners issued, then rounds and saturates.
// ----------------------------------------------------------------------------
module vgts_mac #(
	parameter int COMPONENT_BITS = 16
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  vgts_pkg::mac_ctrl_t                   ctrl,
	input  logic [vgts_pkg::WORD_W-1:0]           rdata,
	output logic                                  busy,
	output logic [2:0][COMPONENT_BITS-1:0]        flow
);

	localparam int VEC_W  = vgts_pkg::VEC_W;
	localparam int T_W    = vgts_pkg::T_W;
	localparam int WT_W   = T_W + 1;
	localparam int WXY_W  = 2 * WT_W - 1;
	localparam int W_W    = 3 * WT_W - 2;
	localparam int PROD_W = VEC_W + W_W + 1;
	// The eight weights always add up to exactly one, so the sum does not grow.
	localparam int ACC_W  = PROD_W;
	localparam int RND_SH = 3 * T_W;
	localparam int Q_W    = ACC_W - RND_SH;
	localparam int SAT_W  = 34;

	localparam logic [WT_W-1:0] W_ONE = WT_W'(1) << T_W;
	localparam logic signed [ACC_W-1:0] RND_HALF = ACC_W'(1) << (RND_SH - 1);
	localparam logic signed [SAT_W-1:0] SAT_HI =
		$signed((SAT_W'(1) << (COMPONENT_BITS - 1)) - SAT_W'(1));
	localparam logic signed [SAT_W-1:0] SAT_LO = ~SAT_HI;

	logic [WT_W-1:0]  wx, wy, wz;
	logic             v_s1, v_s2, v_s3;
	logic [WXY_W-1:0] wxy_s1;
	logic [WT_W-1:0]  wz_s1;
	logic [W_W-1:0]   w_s2;
	logic [vgts_pkg::WORD_W-1:0] data_s2;
	logic signed [VEC_W-1:0]  comp [3];
	logic signed [W_W:0]      w_sg;
	logic signed [PROD_W-1:0] prod [3];
	logic signed [PROD_W-1:0] prod_s3 [3];
	logic signed [ACC_W-1:0]  acc_q [3];
	logic signed [ACC_W-1:0]  rnd [3];
	logic signed [SAT_W-1:0]  ext [3];
	logic signed [SAT_W-1:0]  sat [3];

	always_comb begin
		wx = ctrl.corner[0] ? {1'b0, ctrl.tx} : W_ONE - {1'b0, ctrl.tx};
		wy = ctrl.corner[1] ? {1'b0, ctrl.ty} : W_ONE - {1'b0, ctrl.ty};
		wz = ctrl.corner[2] ? {1'b0, ctrl.tz} : W_ONE - {1'b0, ctrl.tz};
	end

	always_comb begin
		w_sg = $signed({1'b0, w_s2});
		for (int k = 0; k < 3; k++) begin
			comp[k] = $signed(data_s2[k*VEC_W +: VEC_W]);
			prod[k] = comp[k] * w_sg;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= ctrl.issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// Stage 1 forms the xy weight while the memory read is under way, stage 2
	// adds z and captures the read data, stage 3 holds the products.
	always_ff @(posedge clk) begin
		wxy_s1  <= {{(WXY_W-WT_W){1'b0}}, wx} * wy;
		wz_s1   <= wz;
		w_s2    <= {{(W_W-WXY_W){1'b0}}, wxy_s1} * wz_s1;
		data_s2 <= rdata;
		for (int k = 0; k < 3; k++) begin
			prod_s3[k] <= prod[k];
			if (ctrl.clear) begin
				acc_q[k] <= '0;
			end else if (v_s3) begin
				acc_q[k] <= acc_q[k] + prod_s3[k];
			end
		end
	end

	// Round half up at the weight scale, then clamp to the result width.
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			rnd[k] = acc_q[k] + RND_HALF;
			ext[k] = $signed({{(SAT_W-Q_W){rnd[k][ACC_W-1]}}, rnd[k][ACC_W-1:RND_SH]});
			if (ext[k] > SAT_HI) begin
				sat[k] = SAT_HI;
			end else if (ext[k] < SAT_LO) begin
				sat[k] = SAT_LO;
			end else begin
				sat[k] = ext[k];
			end
			flow[k] = sat[k][COMPONENT_BITS-1:0];
		end
	end

	assign busy = v_s1 | v_s2 | v_s3;

endmodule

// File: src/vector_grid_trilinear_sampler_unit.sv
// ----------------------------------------------------------------------------
// vector_grid_trilinear_sampler_unit: wind vector grid with trilinear lookup
// A grid of three-component wind vectors in one single-port memory, written
// cell by cell and sampled by world position, trilinear or nearest cell.
// ----------------------------------------------------------------------------
// Usage. Items arrive on the item channel. Action write stores vec_x..vec_z at
// cell (cell_x, cell_y, cell_z) and produces no result; a cell index beyond the
// grid is dropped. Action trilinear and action nearest map pos_x..pos_z into
// cell space and return one transfer on the result channel with the sampled
// vector and in_range. A query whose base cell is not strictly inside the grid
// returns a zero vector with in_range low and touches no memory. Action three
// is dropped. Register writes (root cell offsets) arrive on the cfg channel,
// which is always ready; they are to be written only while no item is in flight,
// a rule on the user that the block does not enforce. An item passes decode,
// ST_ROW and ST_ADDR, then a write, or the corner reads and a pipeline drain;
// an out-of-range query goes from decode to the result. Trilinear sampling
// makes eight corner reads from the single grid memory port, one per cycle,
// into the weighting pipeline. One item is worked on at a time, so a read never
// meets a pending write. The result sits in an output register: the next item
// is accepted while it waits, and only the delivery of a new result waits for
// the receiver. Reset clears the controller, the result valid and the root offsets;
// grid cells hold nothing defined until written, and no clearing pass is run.
// ----------------------------------------------------------------------------
module vector_grid_trilinear_sampler_unit #(
	parameter int GRID_X         = 32,
	parameter int GRID_Y         = 32,
	parameter int GRID_Z         = 16,
	parameter int COMPONENT_BITS = 16
) (
	input  logic            clk,
	input  logic            arst_n,
	vgts_cfg_if.sink        cfg,
	vgts_item_if.sink       item,
	vgts_result_if.source   result
);

	localparam int POS_W   = vgts_pkg::POS_W;
	localparam int CFG_W   = vgts_pkg::CFG_W;
	localparam int COORD_W = vgts_pkg::COORD_W;
	localparam int BASE_W  = vgts_pkg::BASE_W;
	localparam int FRAC_W  = vgts_pkg::FRAC_W;
	localparam int T_W     = vgts_pkg::T_W;
	localparam int WORD_W  = vgts_pkg::WORD_W;
	localparam int DEPTH   = GRID_X * GRID_Y * GRID_Z;
	localparam int AW      = $clog2(DEPTH);
	localparam int XW      = $clog2(GRID_X);
	localparam int YW      = $clog2(GRID_Y);
	localparam int ZW      = $clog2(GRID_Z);

	// Cell space origin: half the grid in x and y, a quarter in z, at eight
	// fraction bits. The upper limit is the last cell; a base must lie below it.
	localparam logic [COORD_W-1:0] OFF_X = COORD_W'(GRID_X * 128);
	localparam logic [COORD_W-1:0] OFF_Y = COORD_W'(GRID_Y * 128);
	localparam logic [COORD_W-1:0] OFF_Z = COORD_W'(GRID_Z * 64);
	localparam logic [BASE_W-1:0]  LIM_X = BASE_W'(GRID_X - 1);
	localparam logic [BASE_W-1:0]  LIM_Y = BASE_W'(GRID_Y - 1);
	localparam logic [BASE_W-1:0]  LIM_Z = BASE_W'(GRID_Z - 1);

	// Map one axis of a world position to a base cell and a weight fraction.
	// The shift by six is the division by 64, rounding toward minus infinity.
	// For trilinear sampling half a cell is taken off first, so the base steps
	// down where the fraction is below one half.
	function automatic vgts_pkg::axis_t axis_decode(
		input logic [POS_W-1:0]   pos,
		input logic [CFG_W-1:0]   root,
		input logic [COORD_W-1:0] off,
		input logic [BASE_W-1:0]  lim,
		input logic               half
	);
		logic [COORD_W-1:0] c;
		logic signed [BASE_W-1:0] b;
		vgts_pkg::axis_t r;
		c = {{(COORD_W-POS_W+6){pos[POS_W-1]}}, pos[POS_W-1:6]} + off
		    - {{(COORD_W-CFG_W-FRAC_W){root[CFG_W-1]}}, root, {FRAC_W{1'b0}}}
		    - (half ? COORD_W'(128) : COORD_W'(0));
		b = $signed(c[COORD_W-1:FRAC_W]);
		r.ok   = (b > $signed(BASE_W'(0))) && (b < $signed(lim));
		r.base = c[COORD_W-1:FRAC_W];
		r.t    = half ? c[T_W-1:0] : '0;
		return r;
	endfunction

	vgts_pkg::state_t state_q, state_d;

	// Register file.
	logic [CFG_W-1:0] root_x_q, root_y_q, root_z_q;

	// Item held for the whole of its processing.
	logic [1:0]                   act_q;
	logic [POS_W-1:0]             pos_x_q, pos_y_q, pos_z_q;
	logic [vgts_pkg::CELL_XW-1:0] cell_x_q;
	logic [vgts_pkg::CELL_YW-1:0] cell_y_q;
	logic [vgts_pkg::CELL_ZW-1:0] cell_z_q;
	logic [WORD_W-1:0]            vec_q;

	// Decoded cell, weights and range flag.
	vgts_pkg::axis_t ax, ay, az;
	logic            is_tri, is_write, query_ok, cell_ok;
	logic [XW-1:0]   ix_q;
	logic [YW-1:0]   iy_q;
	logic [ZW-1:0]   iz_q;
	logic [T_W-1:0]  tx_q, ty_q, tz_q;
	logic            ok_q;

	// Address generation and the grid memory.
	logic [AW-1:0]     row_q, addr_q, corner_off, mem_addr;
	logic [2:0]        corner_q;
	logic              mem_we, mem_re;
	logic [WORD_W-1:0] grid_mem [DEPTH];
	logic [WORD_W-1:0] mem_rdata_q;

	// Accumulation pipeline and result register.
	vgts_pkg::mac_ctrl_t           mac_ctrl;
	logic                          mac_busy;
	logic [2:0][COMPONENT_BITS-1:0] mac_flow;
	logic                          load_result;
	logic                          res_valid_q;
	logic [COMPONENT_BITS-1:0]     flow_x_q, flow_y_q, flow_z_q;
	logic                          in_range_q;

	// ------------------------------------------------------------------
	// Register writes. Indexes beyond the list are accepted and ignored.
	// ------------------------------------------------------------------
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			root_x_q <= '0;
			root_y_q <= '0;
			root_z_q <= '0;
		end else if (cfg.valid) begin
			case (cfg.index)
				vgts_pkg::REG_ROOT_X: root_x_q <= cfg.data;
				vgts_pkg::REG_ROOT_Y: root_y_q <= cfg.data;
				vgts_pkg::REG_ROOT_Z: root_z_q <= cfg.data;
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Item capture and decode.
	// ------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			act_q    <= item.action;
			pos_x_q  <= item.pos_x;
			pos_y_q  <= item.pos_y;
			pos_z_q  <= item.pos_z;
			cell_x_q <= item.cell_x;
			cell_y_q <= item.cell_y;
			cell_z_q <= item.cell_z;
			vec_q    <= {item.vec_z, item.vec_y, item.vec_x};
		end
	end

	always_comb begin
		is_tri   = (act_q == vgts_pkg::ACT_TRILINEAR);
		is_write = (act_q == vgts_pkg::ACT_WRITE);
		ax       = axis_decode(pos_x_q, root_x_q, OFF_X, LIM_X, is_tri);
		ay       = axis_decode(pos_y_q, root_y_q, OFF_Y, LIM_Y, is_tri);
		az       = axis_decode(pos_z_q, root_z_q, OFF_Z, LIM_Z, is_tri);
		query_ok = ax.ok && ay.ok && az.ok;
		cell_ok  = (int'(cell_x_q) < GRID_X) && (int'(cell_y_q) < GRID_Y)
		           && (int'(cell_z_q) < GRID_Z);
	end

	always_ff @(posedge clk) begin
		if (state_q == vgts_pkg::ST_DECODE) begin
			if (is_write) begin
				ix_q <= XW'(cell_x_q);
				iy_q <= YW'(cell_y_q);
				iz_q <= ZW'(cell_z_q);
			end else begin
				ix_q <= ax.base[XW-1:0];
				iy_q <= ay.base[YW-1:0];
				iz_q <= az.base[ZW-1:0];
			end
			tx_q <= ax.t;
			ty_q <= ay.t;
			tz_q <= az.t;
			ok_q <= query_ok;
		end
	end

	// ------------------------------------------------------------------
	// Linear cell address, built in two steps, ST_ROW then ST_ADDR, so that each
	// step holds a single multiplication by a grid size. The corners of the trilinear
	// cube sit at fixed offsets from the base cell.
	// ------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (state_q == vgts_pkg::ST_ROW) begin
			row_q <= AW'(iz_q * GRID_Y + iy_q);
		end
		if (state_q == vgts_pkg::ST_ADDR) begin
			addr_q <= AW'(row_q * GRID_X + ix_q);
		end
	end

	always_comb begin
		corner_off = (corner_q[0] ? AW'(1) : AW'(0))
		           + (corner_q[1] ? AW'(GRID_X) : AW'(0))
		           + (corner_q[2] ? AW'(GRID_X * GRID_Y) : AW'(0));
		mem_addr   = addr_q + corner_off;
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			grid_mem[mem_addr] <= vec_q;
		end else if (mem_re) begin
			mem_rdata_q <= grid_mem[mem_addr];
		end
	end

	// ------------------------------------------------------------------
	// Sequencer.
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= vgts_pkg::ST_IDLE;
			corner_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == vgts_pkg::ST_DECODE) begin
				corner_q <= '0;
			end else if (state_q == vgts_pkg::ST_READ) begin
				corner_q <= corner_q + 3'd1;
			end
		end
	end

	always_comb begin
		state_d     = state_q;
		item.ready  = 1'b0;
		mem_we      = 1'b0;
		mem_re      = 1'b0;
		load_result = 1'b0;
		mac_ctrl    = '{clear: 1'b0, issue: 1'b0, corner: corner_q,
		                tx: tx_q, ty: ty_q, tz: tz_q};
		case (state_q)
			vgts_pkg::ST_IDLE: begin
				item.ready = 1'b1;
				if (item.valid) begin
					state_d = vgts_pkg::ST_DECODE;
				end
			end
			vgts_pkg::ST_DECODE: begin
				mac_ctrl.clear = 1'b1;
				case (act_q)
					vgts_pkg::ACT_WRITE: begin
						state_d = cell_ok ? vgts_pkg::ST_ROW : vgts_pkg::ST_IDLE;
					end
					vgts_pkg::ACT_TRILINEAR, vgts_pkg::ACT_NEAREST: begin
						state_d = query_ok ? vgts_pkg::ST_ROW : vgts_pkg::ST_RESULT;
					end
					default: begin
						state_d = vgts_pkg::ST_IDLE;
					end
				endcase
			end
			vgts_pkg::ST_ROW: begin
				state_d = vgts_pkg::ST_ADDR;
			end
			vgts_pkg::ST_ADDR: begin
				state_d = is_write ? vgts_pkg::ST_WRITE : vgts_pkg::ST_READ;
			end
			vgts_pkg::ST_WRITE: begin
				mem_we  = 1'b1;
				state_d = vgts_pkg::ST_IDLE;
			end
			vgts_pkg::ST_READ: begin
				// Nearest reads the base cell alone; its weight is exactly one.
				mem_re         = 1'b1;
				mac_ctrl.issue = 1'b1;
				if (!is_tri || corner_q == 3'd7) begin
					state_d = vgts_pkg::ST_DRAIN;
				end
			end
			vgts_pkg::ST_DRAIN: begin
				if (!mac_busy) begin
					state_d = vgts_pkg::ST_RESULT;
				end
			end
			vgts_pkg::ST_RESULT: begin
				if (!res_valid_q || result.ready) begin
					load_result = 1'b1;
					state_d     = vgts_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = vgts_pkg::ST_IDLE;
			end
		endcase
	end

	vgts_mac #(
		.COMPONENT_BITS(COMPONENT_BITS)
	) u_mac (
		.clk   (clk),
		.arst_n(arst_n),
		.ctrl  (mac_ctrl),
		.rdata (mem_rdata_q),
		.busy  (mac_busy),
		.flow  (mac_flow)
	);

	// ------------------------------------------------------------------
	// Result register. A query outside the grid interior returns zero.
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (load_result) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_result) begin
			flow_x_q   <= ok_q ? mac_flow[0] : '0;
			flow_y_q   <= ok_q ? mac_flow[1] : '0;
			flow_z_q   <= ok_q ? mac_flow[2] : '0;
			in_range_q <= ok_q;
		end
	end

	assign result.valid    = res_valid_q;
	assign result.flow_x   = flow_x_q;
	assign result.flow_y   = flow_y_q;
	assign result.flow_z   = flow_z_q;
	assign result.in_range = in_range_q;

endmodule
